// ===== src/dics_pkg.sv =====
// Shared types and codes for the discrete inverse-CDF sampler.
package dics_pkg;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // input transaction
    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] bin_value;
        logic [15:0]        weight;
        logic [31:0]        random_fraction;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [5:0]         sample_index;
        logic [1:0]         status;
    } t_out_item;

    // search wavefront handed from cell to cell
    typedef struct packed {
        logic               found;
        logic [5:0]         index;
        logic signed [31:0] value;
    } t_wave;

endpackage

// ===== src/dics_thr_unit.sv =====
// Threshold unit: ceil(fraction * total / 2^RAND_BITS) over three registered stages.
module dics_thr_unit #(
    parameter int RAND_BITS = 32,
    parameter int CUM_W     = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [RAND_BITS-1:0] i_frac,
    input  logic [CUM_W-1:0]     i_total,
    output logic                 o_done,
    output logic [CUM_W:0]       o_thr
);
    import dics_pkg::*;

    localparam int LO_W   = (CUM_W + 1) / 2;
    localparam int HI_W   = CUM_W - LO_W;
    localparam int PROD_W = RAND_BITS + CUM_W;

    logic [RAND_BITS+LO_W-1:0] r_plo;
    logic [RAND_BITS+HI_W-1:0] r_phi;
    logic [PROD_W-1:0]         r_prod;
    logic [CUM_W:0]            r_thr;
    logic [2:0]                r_vld;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_go};
        end
    end

    // split product, recombine, then round up the integer part
    always_ff @(posedge i_clk) begin
        r_plo  <= i_frac * i_total[LO_W-1:0];
        r_phi  <= i_frac * i_total[CUM_W-1:LO_W];
        r_prod <= PROD_W'(r_plo) + (PROD_W'(r_phi) << LO_W);
        r_thr  <= (CUM_W+1)'(r_prod[PROD_W-1:RAND_BITS])
                + (CUM_W+1)'(|r_prod[RAND_BITS-1:0]);
    end

    assign o_done = r_vld[2];
    assign o_thr  = r_thr;

endmodule

// ===== src/dics_cell.sv =====
// One table cell: holds a bin and its cumulative weight, passes the search wave on.
module dics_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7,
    parameter int CUM_W = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [CNT_W-1:0]    i_count,
    input  logic signed [31:0]  i_wr_value,
    input  logic [CUM_W-1:0]    i_wr_cum,
    input  logic [CUM_W:0]      i_thr,
    input  dics_pkg::t_wave     i_wave,
    output dics_pkg::t_wave     o_wave
);
    import dics_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [31:0] r_value;
    logic [CUM_W-1:0]   r_cum;
    t_wave              r_wave;
    t_wave              n_wave;
    logic               w_meet;

    // entry write, addressed by the fill count
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_count == MY_IDX)) begin
            r_value <= i_wr_value;
            r_cum   <= i_wr_cum;
        end
    end

    // first qualifying cell claims the wave
    always_comb begin
        w_meet = (MY_IDX < i_count) && ({1'b0, r_cum} >= i_thr);
        n_wave = i_wave;
        if (!i_wave.found && w_meet) begin
            n_wave.found = 1'b1;
            n_wave.index = 6'(IDX);
            n_wave.value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_wave = r_wave;

endmodule

// ===== src/discrete_inverse_cdf_sampler_core.sv =====
// Top level of the discrete inverse-CDF sampler: command FSM, table chain, threshold unit.
//
//  channel  | ports                       | transfer
//  ---------+-----------------------------+-----------------------------------------
//  command  | i_start, o_busy, i_item     | edge with i_start high and o_busy low
//  result   | o_done, o_result            | edge ending the one cycle o_done is high
//
// Clear, append and the unused command give their result one cycle after
// acceptance, as does a sample of an empty or zero-total table.
// A sample passes through S_THR (the three threshold unit stages plus the
// turnaround), then S_SEARCH while the wave walks the cell chain one cell per
// cycle and the result is registered.
// Reset is synchronous and active low; it empties the table (count and total).
// o_busy is high for the whole sample; results cannot be stalled.
module discrete_inverse_cdf_sampler_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int WEIGHT_BITS = 16,
    parameter int RAND_BITS   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  dics_pkg::t_in_item   i_item,
    output logic                 o_busy,
    output logic                 o_done,
    output dics_pkg::t_out_item  o_result
);
    import dics_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CUM_W = WEIGHT_BITS + $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_THR, S_SEARCH} t_state;

    t_state                r_state;
    logic                  r_done;
    t_out_item             r_out;
    logic [CNT_W-1:0]      r_count;
    logic [CUM_W-1:0]      r_total;
    logic [RAND_BITS-1:0]  r_frac;
    logic                  r_go;
    logic [CNT_W-1:0]      r_scnt;

    logic                  w_accept;
    logic                  w_full;
    logic [31:0]           w_wext;
    logic [CUM_W-1:0]      n_total;
    logic                  w_wr_en;
    logic                  w_thr_done;
    logic [CUM_W:0]        w_thr;
    t_wave                 w_chain [TABLE_DEPTH+1];

    // decode helpers
    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_full   = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_wext   = 32'(i_item.weight);
    assign n_total  = r_total + CUM_W'(w_wext[WEIGHT_BITS-1:0]);
    assign w_wr_en  = w_accept && (i_item.command == CMD_APPEND) && !w_full;

    // threshold unit
    dics_thr_unit #(
        .RAND_BITS (RAND_BITS),
        .CUM_W     (CUM_W)
    ) u_thr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_frac  (r_frac),
        .i_total (r_total),
        .o_done  (w_thr_done),
        .o_thr   (w_thr)
    );

    // cell chain, wave enters empty at cell 0
    assign w_chain[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        dics_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .CUM_W (CUM_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_wr_en),
            .i_count    (r_count),
            .i_wr_value (i_item.bin_value),
            .i_wr_cum   (n_total),
            .i_thr      (w_thr),
            .i_wave     (w_chain[g]),
            .o_wave     (w_chain[g+1])
        );
    end

    // command FSM and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_out   <= '0;
            r_count <= '0;
            r_total <= '0;
            r_go    <= 1'b0;
            r_scnt  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        unique case (i_item.command)
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_total <= '0;
                                r_out   <= '0;
                                r_done  <= 1'b1;
                                r_go    <= 1'b0;
                            end
                            CMD_APPEND: begin
                                if (w_full) begin
                                    r_out <= '{sample_value: '0,
                                               sample_index: '0,
                                               status:       ST_FULL};
                                end else begin
                                    r_out <= '{sample_value: '0,
                                               sample_index: 6'(r_count),
                                               status:       ST_OK};
                                    r_count <= r_count + CNT_W'(1);
                                    r_total <= n_total;
                                end
                                r_done <= 1'b1;
                                r_go   <= 1'b0;
                            end
                            CMD_SAMPLE: begin
                                if ((r_count == '0) || (r_total == '0)) begin
                                    r_out <= '{sample_value: '0,
                                               sample_index: '0,
                                               status:       ST_EMPTY};
                                    r_done <= 1'b1;
                                    r_go   <= 1'b0;
                                end else begin
                                    r_frac  <= i_item.random_fraction[RAND_BITS-1:0];
                                    r_done  <= 1'b0;
                                    r_go    <= 1'b1;
                                    r_state <= S_THR;
                                end
                            end
                            default: begin
                                r_out  <= '0;
                                r_done <= 1'b1;
                                r_go   <= 1'b0;
                            end
                        endcase
                    end else begin
                        r_done <= 1'b0;
                        r_go   <= 1'b0;
                    end
                end
                S_THR: begin
                    r_done <= 1'b0;
                    r_go   <= 1'b0;
                    if (w_thr_done) begin
                        r_scnt  <= '0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_go <= 1'b0;
                    // wave has cleared the last cell once r_scnt reaches TABLE_DEPTH
                    if (r_scnt == CNT_W'(TABLE_DEPTH)) begin
                        r_out <= '{sample_value: w_chain[TABLE_DEPTH].value,
                                   sample_index: w_chain[TABLE_DEPTH].index,
                                   status:       ST_OK};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_done <= 1'b0;
                        r_scnt <= r_scnt + CNT_W'(1);
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_go    <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_done || o_busy))
        else $error("accepted transaction neither answered nor in progress");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_FULL)) |-> w_full)
        else $error("full status with room in table");

endmodule

// ===== tb/tb_discrete_inverse_cdf_sampler_core.sv =====
// Self-checking testbench for the discrete inverse-CDF sampler core.
module tb_discrete_inverse_cdf_sampler_core;
    import dics_pkg::*;

    localparam int         DEPTH        = 64;
    localparam int         ITEM_TARGET  = 1320;
    localparam int         DRAIN_CYCLES = DEPTH + 16;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_busy;
    logic      o_done;
    t_out_item o_result;

    // table shadow: bin values, cumulative weights, fill level, weight total
    logic signed [31:0] bin_table [DEPTH];
    logic [21:0]        cum_table [DEPTH];
    int                 table_fill = 0;
    logic [21:0]        weight_sum = '0;

    t_in_item  cmd_backlog[$];
    t_out_item outcomes_due[$];
    int        posted_total   = 0;
    int        counted_items  = 0;
    int        accepted_count = 0;
    int        fault_count    = 0;
    int        burst_left     = 1;
    int        gap_left       = 0;

    discrete_inverse_cdf_sampler_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cum / total >= frac / 2^32, compared without division
    function automatic bit cum_reaches(input logic [21:0] cum, input logic [31:0] frac,
                                       input logic [21:0] total);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = {10'd0, cum, 32'd0};
        rhs = 64'(frac) * 64'(total);
        return lhs >= rhs;
    endfunction

    // apply one command to the shadow table and return its result
    function automatic t_out_item apply_command(input t_in_item cmd_in);
        t_out_item res;
        int        pick;
        int        k;
        res = '0;
        case (cmd_in.command)
            CMD_CLEAR: begin
                table_fill = 0;
                weight_sum = '0;
            end
            CMD_APPEND: begin
                if (table_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    weight_sum = weight_sum + 22'(cmd_in.weight);
                    bin_table[table_fill] = cmd_in.bin_value;
                    cum_table[table_fill] = weight_sum;
                    res.sample_index = table_fill[5:0];
                    table_fill++;
                end
            end
            CMD_SAMPLE: begin
                if (table_fill == 0 || weight_sum == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // lowest bin that reaches the threshold; the last always does
                    pick = table_fill - 1;
                    for (k = table_fill - 1; k >= 0; k--) begin
                        if (cum_reaches(cum_table[k], cmd_in.random_fraction, weight_sum))
                            pick = k;
                    end
                    res.sample_value = bin_table[pick];
                    res.sample_index = pick[5:0];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic post_item(input logic [1:0] cmd, input logic [31:0] value,
                             input logic [15:0] weight, input logic [31:0] frac);
        t_in_item it;
        it.command         = cmd;
        it.bin_value       = value;
        it.weight          = weight;
        it.random_fraction = frac;
        cmd_backlog.push_back(it);
        if (cmd != CMD_UNUSED)
            counted_items++;
    endtask

    // n appends; wstyle picks the weight profile of the table
    task automatic fill_table(input int n, input int wstyle);
        logic [15:0] w;
        int          j;
        for (j = 0; j < n; j++) begin
            case (wstyle)
                0:       w = '0;
                1:       w = 16'($urandom_range(0, 3));
                2:       w = 16'($urandom);
                3:       w = 16'hFFFF;
                default: w = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            endcase
            post_item(CMD_APPEND, $urandom, w, $urandom);
        end
    endtask

    // m draws, with the fraction extremes mixed in
    task automatic draw_samples(input int m);
        logic [31:0] f;
        int          j;
        for (j = 0; j < m; j++) begin
            case ($urandom_range(0, 19))
                0:       f = 32'h0000_0000;
                1:       f = 32'hFFFF_FFFF;
                2:       f = 32'h0000_0001;
                3:       f = 32'h8000_0000;
                default: f = $urandom;
            endcase
            post_item(CMD_SAMPLE, $urandom, 16'($urandom), f);
        end
    endtask

    function automatic int pick_wstyle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r <= 2) return 1;
        if (r <= 6) return 2;
        if (r == 7) return 3;
        return 4;
    endfunction

    task automatic note_fault(input string what, input t_out_item want, input t_out_item got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t %s: expected %0d/%0d/%0d (value/index/status), got %0d/%0d/%0d",
                     $time, what, want.sample_value, want.sample_index, want.status,
                     got.sample_value, got.sample_index, got.status);
    endtask

    // driver: bursts of commands with random gaps; predicts on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            table_fill = 0;
            weight_sum = '0;
            outcomes_due.delete();
        end else begin
            if (i_start && !o_busy) begin
                outcomes_due.push_back(apply_command(i_item));
                accepted_count++;
            end
            if (!i_start || !o_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_start <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    i_start <= 1'b1;
                    i_item  <= cmd_backlog.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 6);
                            8:          gap_left = $urandom_range(7, 30);
                            default:    gap_left = $urandom_range(40, 90);
                        endcase
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed result must match the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (outcomes_due.size() == 0) begin
                note_fault("result with none expected", '0, o_result);
            end else begin
                want = outcomes_due.pop_front();
                if (o_result.sample_value !== want.sample_value ||
                    o_result.sample_index !== want.sample_index ||
                    o_result.status !== want.status)
                    note_fault("result mismatch", want, o_result);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int r;

        // directed: empty table, unused command, zero total, value extremes
        post_item(CMD_SAMPLE, 32'h1234_5678, 16'h0001, 32'h0000_0000);
        post_item(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        post_item(CMD_APPEND, 32'h8000_0000, 16'h0000, 32'hFFFF_FFFF);
        post_item(CMD_SAMPLE, 32'h0, 16'h0, 32'h0000_0000);
        post_item(CMD_APPEND, 32'h7FFF_FFFF, 16'h0000, 32'h0);
        post_item(CMD_APPEND, 32'h0000_0000, 16'hFFFF, 32'h0);
        post_item(CMD_SAMPLE, 32'h0, 16'h0, 32'h0000_0000);
        post_item(CMD_SAMPLE, 32'h0, 16'h0, 32'hFFFF_FFFF);
        post_item(CMD_SAMPLE, 32'h0, 16'h0, 32'h8000_0000);
        post_item(CMD_APPEND, 32'hFFFF_FFFF, 16'h0001, 32'h0);
        post_item(CMD_SAMPLE, 32'h0, 16'h0, 32'hFFFF_FFFF);
        post_item(CMD_SAMPLE, 32'h0, 16'h0, 32'h0000_0001);
        post_item(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        post_item(CMD_SAMPLE, 32'h0, 16'h0, 32'h4000_0000);
        post_item(CMD_APPEND, 32'h0001_0000, 16'hFFFF, 32'h0);
        post_item(CMD_SAMPLE, 32'h0, 16'h0, 32'h0000_0000);
        post_item(CMD_UNUSED, 32'h0, 16'h0, 32'h0);
        post_item(CMD_SAMPLE, 32'h0, 16'h0, 32'hFFFF_FFFF);

        // full table at maximum weights, appends past the end, then draws
        post_item(CMD_CLEAR, $urandom, 16'($urandom), $urandom);
        fill_table(DEPTH + 2, 3);
        draw_samples(6);

        // random sequences, mostly fresh tables followed by draws
        while (counted_items < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                post_item(CMD_CLEAR, $urandom, 16'($urandom), $urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: fill_table($urandom_range(1, 8), pick_wstyle());
                    6, 7, 8:          fill_table($urandom_range(9, 40), pick_wstyle());
                    default:          fill_table($urandom_range(DEPTH - 2, DEPTH + 3),
                                                 pick_wstyle());
                endcase
                draw_samples($urandom_range(1, 10));
            end else if (r < 75) begin
                fill_table($urandom_range(1, 5), pick_wstyle());
                draw_samples($urandom_range(1, 4));
            end else if (r < 90) begin
                draw_samples($urandom_range(1, 6));
            end else if (r < 95) begin
                post_item(CMD_UNUSED, $urandom, 16'($urandom), $urandom);
            end else begin
                post_item(CMD_CLEAR, $urandom, 16'($urandom), $urandom);
                draw_samples($urandom_range(0, 2));
            end
        end
        posted_total = cmd_backlog.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < posted_total || outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && outcomes_due.size() == 0) begin
            $display("discrete_inverse_cdf_sampler_core verification clean");
        end else begin
            $display("discrete_inverse_cdf_sampler_core verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("discrete_inverse_cdf_sampler_core verification failed");
        $finish;
    end

endmodule
